// ----- rtl/vector3_normalize_assert.svh -----
// assertion macros used by the checker file
`ifndef VECTOR3_NORMALIZE_ASSERT_SVH
`define VECTOR3_NORMALIZE_ASSERT_SVH
// implication checked every clock outside reset
`define V3N_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define V3N_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ----- rtl/v3n_pkg.sv -----
// ----------------------------------------------------------------------------
// v3n_pkg
// shared widths and constants of the vector normalizer
// ----------------------------------------------------------------------------
package v3n_pkg;
    localparam int SUM_W  = 48;
    localparam int MAG_W  = 24;
    localparam int UNIT_W = 24;
    localparam int UNIT_FRAC = 22;
    localparam logic [UNIT_W-1:0] UNIT_ONE = UNIT_W'(1) << UNIT_FRAC;
endpackage

// ----- rtl/v3n_sqrt.sv -----
// ----------------------------------------------------------------------------
// v3n_sqrt
// pipelined floor square root, STEPS result bits per stage
// ----------------------------------------------------------------------------
module v3n_sqrt #(
    parameter int IN_W  = 64,
    parameter int STEPS = 4,
    parameter int TAG_W = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [IN_W-1:0]     i_rad,
    input  logic [TAG_W-1:0]    i_tag,
    output logic                o_valid,
    output logic [IN_W/2-1:0]   o_root,
    output logic [TAG_W-1:0]    o_tag
);
    localparam int RW = IN_W / 2;
    localparam int NST = (RW + STEPS - 1) / STEPS;

    logic [IN_W-1:0]  r_rem  [NST+1];
    logic [IN_W-1:0]  r_rad  [NST+1];
    logic [RW-1:0]    r_root [NST+1];
    logic [TAG_W-1:0] r_tag  [NST+1];
    logic             r_vld  [NST+1];

    assign r_rem[0]  = '0;
    assign r_rad[0]  = i_rad;
    assign r_root[0] = '0;
    assign r_tag[0]  = i_tag;
    assign r_vld[0]  = i_valid;

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [IN_W-1:0] n_rem, n_rad;
        logic [RW-1:0]   n_root;
        // restoring square root, one bit per inner step
        always_comb begin
            logic [IN_W+1:0] t, tr;
            n_rem  = r_rem[s];
            n_rad  = r_rad[s];
            n_root = r_root[s];
            for (int k = 0; k < STEPS; k++) begin
                if (s * STEPS + k < RW) begin
                    tr = {n_rem, n_rad[IN_W-1 -: 2]};
                    t  = tr - {n_root, 2'b01};
                    n_rad = n_rad << 2;
                    if (!t[IN_W+1]) begin
                        n_rem  = t[IN_W-1:0];
                        n_root = {n_root[RW-2:0], 1'b1};
                    end else begin
                        n_rem  = tr[IN_W-1:0];
                        n_root = {n_root[RW-2:0], 1'b0};
                    end
                end
            end
        end
        logic [IN_W-1:0]  q_rem, q_rad;
        logic [RW-1:0]    q_root;
        logic [TAG_W-1:0] q_tag;
        logic             q_vld;
        // stage registers
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                q_vld <= 1'b0;
            end else if (i_en) begin
                q_vld <= r_vld[s];
            end
            if (i_en) begin
                q_rem <= n_rem;
                q_rad <= n_rad;
                q_root <= n_root;
                q_tag <= r_tag[s];
            end
        end
        assign r_rem[s+1] = q_rem;
        assign r_rad[s+1] = q_rad;
        assign r_root[s+1] = q_root;
        assign r_tag[s+1] = q_tag;
        assign r_vld[s+1] = q_vld;
    end

    assign o_valid = r_vld[NST];
    assign o_root  = r_root[NST];
    assign o_tag   = r_tag[NST];
endmodule

// ----- rtl/v3n_div.sv -----
// ----------------------------------------------------------------------------
// v3n_div
// pipelined restoring divider, STEPS quotient bits per stage
// ----------------------------------------------------------------------------
module v3n_div #(
    parameter int N_W   = 53,
    parameter int D_W   = 24,
    parameter int STEPS = 4
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [N_W-1:0] i_num,
    input  logic [D_W-1:0] i_den,
    output logic [N_W-1:0] o_quo
);
    localparam int NST = (N_W + STEPS - 1) / STEPS;

    logic [D_W-1:0] r_rem [NST+1];
    logic [N_W-1:0] r_num [NST+1];
    logic [D_W-1:0] r_den [NST+1];

    assign r_rem[0] = '0;
    assign r_num[0] = i_num;
    assign r_den[0] = i_den;

    for (genvar s = 0; s < NST; s++) begin : g_st
        logic [D_W-1:0] n_rem;
        logic [N_W-1:0] n_num;
        // shift in one dividend bit, subtract if it fits; quotient fills n_num
        always_comb begin
            logic [D_W:0] tr, t;
            n_rem = r_rem[s];
            n_num = r_num[s];
            for (int k = 0; k < STEPS; k++) begin
                if (s * STEPS + k < N_W) begin
                    tr = {n_rem, n_num[N_W-1]};
                    t  = tr - {1'b0, r_den[s]};
                    if (!t[D_W]) begin
                        n_rem = t[D_W-1:0];
                        n_num = {n_num[N_W-2:0], 1'b1};
                    end else begin
                        n_rem = tr[D_W-1:0];
                        n_num = {n_num[N_W-2:0], 1'b0};
                    end
                end
            end
        end
        logic [D_W-1:0] q_rem, q_den;
        logic [N_W-1:0] q_num;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                q_rem <= n_rem;
                q_num <= n_num;
                q_den <= r_den[s];
            end
        end
        assign r_rem[s+1] = q_rem;
        assign r_num[s+1] = q_num;
        assign r_den[s+1] = q_den;
    end

    assign o_quo = r_num[NST];
endmodule

// ----- rtl/vector3_normalize.sv -----
// ----------------------------------------------------------------------------
// vector3_normalize
// 3-D vector magnitude and unit vector, fully pipelined
// ----------------------------------------------------------------------------
// pipeline order: square, sum, square root, divide, output register
// throughput: one request per cycle; a stall freezes the whole pipeline
// reset: synchronous active low, clears stage valid bits only
module vector3_normalize #(
    parameter int COMP_WIDTH = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [23:0]                    i_comp_x,
    input  logic [23:0]                    i_comp_y,
    input  logic [23:0]                    i_comp_z,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [v3n_pkg::SUM_W-1:0]      o_square_sum,
    output logic [v3n_pkg::MAG_W-1:0]      o_magnitude,
    output logic                           o_is_zero,
    output logic signed [v3n_pkg::UNIT_W-1:0] o_unit_x,
    output logic signed [v3n_pkg::UNIT_W-1:0] o_unit_y,
    output logic signed [v3n_pkg::UNIT_W-1:0] o_unit_z
);
    import v3n_pkg::*;

    localparam int CW   = COMP_WIDTH;
    localparam int AW   = CW;              // magnitude of a component fits CW bits
    localparam int SQ_W = 2 * AW + 2;      // sum of three squares, even width
    localparam int RT_W = SQ_W / 2;
    localparam int N_W  = AW + UNIT_FRAC;
    localparam int STEPS = 4;
    localparam int DIV_NST = (N_W + STEPS - 1) / STEPS;
    localparam int TAG_W = 3 * (AW + 1) + SQ_W;

    // pipeline advances when the output is free
    logic w_en;
    assign w_en = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // stage 1: sign split and squares
    logic          r1_vld;
    logic [AW-1:0] r1_ax, r1_ay, r1_az;
    logic [2:0]    r1_neg;
    logic [2*AW-1:0] r1_sx, r1_sy, r1_sz;
    logic [CW-1:0] w_x, w_y, w_z;
    logic [AW-1:0] n1_ax, n1_ay, n1_az;
    assign w_x = CW'(i_comp_x);
    assign w_y = CW'(i_comp_y);
    assign w_z = CW'(i_comp_z);
    assign n1_ax = w_x[CW-1] ? AW'(-w_x) : w_x;
    assign n1_ay = w_y[CW-1] ? AW'(-w_y) : w_y;
    assign n1_az = w_z[CW-1] ? AW'(-w_z) : w_z;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid;
        end
        if (w_en) begin
            r1_ax <= n1_ax;
            r1_ay <= n1_ay;
            r1_az <= n1_az;
            r1_neg <= {w_z[CW-1], w_y[CW-1], w_x[CW-1]};
            r1_sx <= n1_ax * n1_ax;
            r1_sy <= n1_ay * n1_ay;
            r1_sz <= n1_az * n1_az;
        end
    end

    // stage 2: sum of squares
    logic            r2_vld;
    logic [SQ_W-1:0] r2_sum;
    logic [AW:0]     r2_x, r2_y, r2_z;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= r1_vld;
        end
        if (w_en) begin
            r2_sum <= SQ_W'(r1_sx) + SQ_W'(r1_sy) + SQ_W'(r1_sz);
            r2_x <= {r1_neg[0], r1_ax};
            r2_y <= {r1_neg[1], r1_ay};
            r2_z <= {r1_neg[2], r1_az};
        end
    end

    // square root stages, components and sum travel as tag
    logic             w_rt_vld;
    logic [RT_W-1:0]  w_root;
    logic [TAG_W-1:0] w_rt_tag;
    v3n_sqrt #(.IN_W(SQ_W), .STEPS(STEPS), .TAG_W(TAG_W)) u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en), .i_valid(r2_vld),
        .i_rad(r2_sum), .i_tag({r2_sum, r2_z, r2_y, r2_x}),
        .o_valid(w_rt_vld), .o_root(w_root), .o_tag(w_rt_tag)
    );

    logic [AW:0]     w_cx, w_cy, w_cz;
    logic [SQ_W-1:0] w_sum;
    assign {w_sum, w_cz, w_cy, w_cx} = w_rt_tag;

    // three dividers in parallel
    logic [N_W-1:0] w_qx, w_qy, w_qz;
    v3n_div #(.N_W(N_W), .D_W(RT_W), .STEPS(STEPS)) u_div_x (
        .i_clk(i_clk), .i_en(w_en), .i_num({w_cx[AW-1:0], UNIT_FRAC'(0)}),
        .i_den(w_root), .o_quo(w_qx));
    v3n_div #(.N_W(N_W), .D_W(RT_W), .STEPS(STEPS)) u_div_y (
        .i_clk(i_clk), .i_en(w_en), .i_num({w_cy[AW-1:0], UNIT_FRAC'(0)}),
        .i_den(w_root), .o_quo(w_qy));
    v3n_div #(.N_W(N_W), .D_W(RT_W), .STEPS(STEPS)) u_div_z (
        .i_clk(i_clk), .i_en(w_en), .i_num({w_cz[AW-1:0], UNIT_FRAC'(0)}),
        .i_den(w_root), .o_quo(w_qz));

    // delay line for side data along the divider
    logic            r_dl_vld  [DIV_NST];
    logic [2:0]      r_dl_neg  [DIV_NST];
    logic [SQ_W-1:0] r_dl_sum  [DIV_NST];
    logic [RT_W-1:0] r_dl_root [DIV_NST];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIV_NST; i++) r_dl_vld[i] <= 1'b0;
        end else if (w_en) begin
            r_dl_vld[0] <= w_rt_vld;
            for (int i = 1; i < DIV_NST; i++) r_dl_vld[i] <= r_dl_vld[i-1];
        end
        if (w_en) begin
            r_dl_neg[0] <= {w_cz[AW], w_cy[AW], w_cx[AW]};
            r_dl_sum[0] <= w_sum;
            r_dl_root[0] <= w_root;
            for (int i = 1; i < DIV_NST; i++) begin
                r_dl_neg[i] <= r_dl_neg[i-1];
                r_dl_sum[i] <= r_dl_sum[i-1];
                r_dl_root[i] <= r_dl_root[i-1];
            end
        end
    end

    // clamp, sign and zero handling
    function automatic logic [UNIT_W-1:0] f_unit(input logic [N_W-1:0] q,
                                                  input logic neg, input logic zero);
        logic [UNIT_W-1:0] m;
        if (zero) return '0;
        m = (q > N_W'(UNIT_ONE)) ? UNIT_ONE : q[UNIT_W-1:0];
        return neg ? -m : m;
    endfunction

    localparam int LT = DIV_NST - 1;
    logic w_zero;
    assign w_zero = (r_dl_root[LT] == '0);

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r_dl_vld[LT];
        end
        if (w_en) begin
            o_square_sum <= SUM_W'(r_dl_sum[LT]);
            o_magnitude <= MAG_W'(r_dl_root[LT]);
            o_is_zero <= w_zero;
            o_unit_x <= f_unit(w_qx, r_dl_neg[LT][0], w_zero);
            o_unit_y <= f_unit(w_qy, r_dl_neg[LT][1], w_zero);
            o_unit_z <= f_unit(w_qz, r_dl_neg[LT][2], w_zero);
        end
    end
endmodule

// ----- rtl/v3n_checker.sv -----
// ----------------------------------------------------------------------------
// v3n_checker
// port-level checks of the vector normalizer
// ----------------------------------------------------------------------------
`include "vector3_normalize_assert.svh"
module v3n_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_is_zero,
    input logic [23:0] o_magnitude,
    input logic [23:0] o_unit_x,
    input logic [47:0] o_square_sum
);
    `V3N_ASSERT_IMP(a_stall_src, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `V3N_ASSERT_IMP(a_zero_mag, i_clk, i_rst_n, o_valid, o_is_zero == (o_magnitude == 24'd0))
    `V3N_ASSERT_IMP(a_zero_unit, i_clk, i_rst_n, o_valid && o_is_zero, o_unit_x == 24'd0)
    `V3N_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_square_sum))
endmodule

bind vector3_normalize v3n_checker u_v3n_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall), .o_valid(o_valid),
    .i_stall(i_stall), .o_is_zero(o_is_zero), .o_magnitude(o_magnitude),
    .o_unit_x(o_unit_x), .o_square_sum(o_square_sum)
);
